[rtl/core/spmg_pkg.sv]
package spmg_pkg;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_QIDX,
    ST_DIV,
    ST_MUL,
    ST_USE,
    ST_RED,
    ST_CORD,
    ST_CRND,
    ST_BND,
    ST_EMIT
  } st_t;

  // Result kinds.
  localparam logic [1:0] KIND_VERTEX = 2'd0;
  localparam logic [1:0] KIND_INDEX  = 2'd1;
  localparam logic [1:0] KIND_BMIN   = 2'd2;
  localparam logic [1:0] KIND_BMAX   = 2'd3;

  // Configuration register indexes.
  localparam logic [2:0] REG_RADIUS = 3'd0;
  localparam logic [2:0] REG_WIDTH  = 3'd1;
  localparam logic [2:0] REG_HEIGHT = 3'd2;
  localparam logic [2:0] REG_COLS   = 3'd3;
  localparam logic [2:0] REG_ROWS   = 3'd4;

  // Steps of the shared multiplier sequence.
  localparam logic [2:0] MS_PHI   = 3'd0;
  localparam logic [2:0] MS_THETA = 3'd1;
  localparam logic [2:0] MS_NX    = 3'd2;
  localparam logic [2:0] MS_NZ    = 3'd3;
  localparam logic [2:0] MS_PY    = 3'd4;
  localparam logic [2:0] MS_RCP   = 3'd5;
  localparam logic [2:0] MS_PX    = 3'd6;
  localparam logic [2:0] MS_PZ    = 3'd7;

  // Angle constants in units of 2^-13 rad, CORDIC start in Q4.24.
  localparam logic signed [17:0] ANG_PI      = 18'sd25736;
  localparam logic signed [17:0] ANG_2PI     = 18'sd51472;
  localparam logic signed [17:0] ANG_HALF_PI = 18'sd12868;
  localparam logic signed [27:0] CORDIC_X0   = 28'sd10188014;

  localparam logic signed [16:0] BOUND_HI = 17'sd65535;
  localparam logic signed [16:0] BOUND_LO = -17'sd65535;

  // Arctangent of 2^-i in units of 2^-16 rad.
  function automatic logic [16:0] atan_val(input logic [4:0] i);
    logic [16:0] r;
    case (i)
      5'd0:    r = 17'd51472;
      5'd1:    r = 17'd30385;
      5'd2:    r = 17'd16055;
      5'd3:    r = 17'd8150;
      5'd4:    r = 17'd4091;
      5'd5:    r = 17'd2047;
      5'd6:    r = 17'd1024;
      5'd7:    r = 17'd512;
      5'd8:    r = 17'd256;
      5'd9:    r = 17'd128;
      5'd10:   r = 17'd64;
      5'd11:   r = 17'd32;
      5'd12:   r = 17'd16;
      5'd13:   r = 17'd8;
      5'd14:   r = 17'd4;
      5'd15:   r = 17'd2;
      5'd16:   r = 17'd1;
      default: r = 17'd0;
    endcase
    return r;
  endfunction

endpackage

[rtl/core/sphere_patch_mesh_generator.sv]
// Channel  | Dir | Handshake             | Payload
// in_      | in  | in_tvalid/in_tready   | tuser: cmd; tdata: grid_row, grid_col
// out_     | out | out_tvalid/out_tready | tuser: kind; tdata: position, normal, uv, index
// cfg_     | in  | cfg_valid/cfg_ready   | cfg_addr register index, cfg_data value
//
// A vertex item takes two 24-step restoring divisions, two CORDIC runs of
// CORDIC_STEPS steps each and eight passes through the shared multiplier.
// A quad item forms its base index and then issues six indices.
// The shared multiplier and the one-step divider set the pace of a vertex item.
// Reset is synchronous and active low; it restores the state, configuration and bounds.
// in_tready is high only while the sequencer is idle; a stalled output holds the sequencer.
module sphere_patch_mesh_generator #(
  parameter int GRID_MAX     = 255,
  parameter int CORDIC_STEPS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [15:0]  in_tdata,    // grid_row [7:0], grid_col [15:8]
  input  logic [0:0]   in_tuser,    // cmd [0]
  output logic         out_tvalid,
  input  logic         out_tready,
  // pos_x [16:0], pos_y [33:17], pos_z [50:34], norm_x [66:51], norm_y [82:67],
  // norm_z [98:83], tex_u [115:99], tex_v [132:116], vertex_index [148:133]
  output logic [151:0] out_tdata,
  output logic [1:0]   out_tuser,   // kind [1:0]
  output logic         out_tlast,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_addr,
  input  logic [15:0]  cfg_data
);

  localparam int ITW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
  localparam logic [7:0] GMAX = 8'(GRID_MAX);

  spmg_pkg::st_t state_r, state_nxt;

  // Configuration registers.
  logic [15:0] radius_r, wang_r, hang_r;
  logic [7:0]  ncols_r, nrows_r;

  // Item registers.
  logic        cmd_r, fin_r;
  logic [7:0]  row_r, col_r;
  logic [15:0] bl_r;

  // Divider.
  logic        div_sel_r;
  logic [4:0]  dcnt_r;
  logic [7:0]  rem_r;
  logic [23:0] dv_r;
  logic [16:0] u_r, v_r;

  // Multiplier sequence and results.
  logic [2:0]          mstep_r;
  logic signed [50:0]  prod_r;
  logic signed [33:0]  q_r;
  logic signed [15:0]  sp_r, cp_r, st_r, ct_r;
  logic signed [15:0]  nx_r, ny_r, nz_r;
  logic signed [16:0]  px_r, py_r, pz_r;
  logic signed [17:0]  ang_r;

  // CORDIC.
  logic signed [27:0]  x_r, y_r;
  logic signed [19:0]  z_r;
  logic [ITW-1:0]      it_r;
  logic                neg_r;

  // Bounds.
  logic signed [16:0] bminx_r, bminy_r, bminz_r, bmaxx_r, bmaxy_r, bmaxz_r;

  // Emission.
  logic [2:0] e_r, n_r;
  logic       out_tvalid_r;
  logic [1:0] okind_r;
  logic       olast_r;
  logic [151:0] odata_r;

  // Effective counts.
  logic [7:0] cols_eff, rows_eff;
  always_comb begin
    cols_eff = (ncols_r == 8'd0) ? 8'd1 : ((ncols_r > GMAX) ? GMAX : ncols_r);
    rows_eff = (nrows_r == 8'd0) ? 8'd1 : ((nrows_r > GMAX) ? GMAX : nrows_r);
  end

  logic in_acc, out_free, emit_load;
  assign in_tready = (state_r == spmg_pkg::ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_tvalid_r || out_tready;
  assign emit_load = (state_r == spmg_pkg::ST_EMIT) && out_free;
  assign cfg_ready = 1'b1;

  // Divider step.
  logic [7:0] dsor;
  logic [8:0] dtrial;
  logic       dge;
  always_comb begin
    dsor   = div_sel_r ? cols_eff : rows_eff;
    dtrial = {rem_r, dv_r[23]};
    dge    = dtrial >= {1'b0, dsor};
  end

  // Shared multiplier operand select.
  logic signed [33:0] mul_a;
  logic signed [16:0] mul_b;
  always_comb begin
    case (mstep_r)
      spmg_pkg::MS_PHI:   begin mul_a = 34'(v_r); mul_b = $signed({1'b0, hang_r}); end
      spmg_pkg::MS_THETA: begin mul_a = 34'(u_r); mul_b = $signed({1'b0, wang_r}); end
      spmg_pkg::MS_NX:    begin mul_a = 34'(cp_r); mul_b = 17'(st_r); end
      spmg_pkg::MS_NZ:    begin mul_a = 34'(cp_r); mul_b = 17'(ct_r); end
      spmg_pkg::MS_PY:    begin mul_a = 34'(radius_r); mul_b = 17'(sp_r); end
      spmg_pkg::MS_RCP:   begin mul_a = 34'(radius_r); mul_b = 17'(cp_r); end
      spmg_pkg::MS_PX:    begin mul_a = q_r; mul_b = 17'(st_r); end
      default:            begin mul_a = q_r; mul_b = 17'(ct_r); end
    endcase
  end

  // Rounding of the registered product.
  logic signed [50:0] p14, p28;
  logic signed [15:0] nrm_c;
  always_comb begin
    p14 = (prod_r + 51'sd8192) >>> 14;
    p28 = (prod_r + 51'sd134217728) >>> 28;
    if (p14 > 51'sd16384)       nrm_c = 16'sd16384;
    else if (p14 < -51'sd16384) nrm_c = -16'sd16384;
    else                        nrm_c = p14[15:0];
  end

  // Angle reduction.
  logic signed [17:0] a1, a2;
  logic               fold;
  always_comb begin
    if (ang_r > spmg_pkg::ANG_PI)       a1 = ang_r - spmg_pkg::ANG_2PI;
    else if (ang_r < -spmg_pkg::ANG_PI) a1 = ang_r + spmg_pkg::ANG_2PI;
    else                                a1 = ang_r;
    fold = 1'b1;
    if (a1 > spmg_pkg::ANG_HALF_PI)       a2 = a1 - spmg_pkg::ANG_PI;
    else if (a1 < -spmg_pkg::ANG_HALF_PI) a2 = a1 + spmg_pkg::ANG_PI;
    else begin
      a2   = a1;
      fold = 1'b0;
    end
  end

  // CORDIC step and final rounding.
  logic signed [27:0] dx, dy, xr_s, yr_s;
  logic signed [19:0] atn;
  logic signed [15:0] xr_c, yr_c;
  always_comb begin
    dx   = y_r >>> it_r;
    dy   = x_r >>> it_r;
    atn  = $signed({3'b000, spmg_pkg::atan_val(5'(it_r))});
    xr_s = (x_r + 28'sd512) >>> 10;
    yr_s = (y_r + 28'sd512) >>> 10;
    if (xr_s > 28'sd16384)       xr_c = 16'sd16384;
    else if (xr_s < -28'sd16384) xr_c = -16'sd16384;
    else                         xr_c = xr_s[15:0];
    if (yr_s > 28'sd16384)       yr_c = 16'sd16384;
    else if (yr_s < -28'sd16384) yr_c = -16'sd16384;
    else                         yr_c = yr_s[15:0];
    if (neg_r) begin
      xr_c = -xr_c;
      yr_c = -yr_c;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      spmg_pkg::ST_IDLE:
        if (in_acc) state_nxt = in_tuser[0] ? spmg_pkg::ST_QIDX : spmg_pkg::ST_DIV;
      spmg_pkg::ST_QIDX: state_nxt = spmg_pkg::ST_EMIT;
      spmg_pkg::ST_DIV:
        if (dcnt_r == 5'd23 && div_sel_r) state_nxt = spmg_pkg::ST_MUL;
      spmg_pkg::ST_MUL: state_nxt = spmg_pkg::ST_USE;
      spmg_pkg::ST_USE: begin
        if (mstep_r == spmg_pkg::MS_PHI || mstep_r == spmg_pkg::MS_THETA)
          state_nxt = spmg_pkg::ST_RED;
        else if (mstep_r == spmg_pkg::MS_PZ)
          state_nxt = spmg_pkg::ST_BND;
        else
          state_nxt = spmg_pkg::ST_MUL;
      end
      spmg_pkg::ST_RED: state_nxt = spmg_pkg::ST_CORD;
      spmg_pkg::ST_CORD:
        if (it_r == ITW'(CORDIC_STEPS - 1)) state_nxt = spmg_pkg::ST_CRND;
      spmg_pkg::ST_CRND: state_nxt = spmg_pkg::ST_MUL;
      spmg_pkg::ST_BND:  state_nxt = spmg_pkg::ST_EMIT;
      spmg_pkg::ST_EMIT:
        if (out_free && (e_r == n_r - 3'd1)) state_nxt = spmg_pkg::ST_IDLE;
      default: state_nxt = spmg_pkg::ST_IDLE;
    endcase
  end

  // Payload of the result being issued.
  logic [15:0] stride16, tl, tr, br, vidx;
  logic [1:0]  kind_c;
  logic        last_c;
  logic [151:0] data_c;
  always_comb begin
    stride16 = {8'd0, cols_eff} + 16'd1;
    tl = bl_r + stride16;
    tr = tl + 16'd1;
    br = bl_r + 16'd1;
    data_c = '0;
    vidx   = '0;
    if (cmd_r) begin
      kind_c = spmg_pkg::KIND_INDEX;
      last_c = (e_r == 3'd5);
      case (e_r)
        3'd0:         vidx = tl;
        3'd1, 3'd4:   vidx = bl_r;
        3'd2, 3'd3:   vidx = tr;
        default:      vidx = br;
      endcase
      data_c[148:133] = vidx;
    end else if (e_r == 3'd0) begin
      kind_c = spmg_pkg::KIND_VERTEX;
      last_c = !fin_r;
      data_c[16:0]    = px_r;
      data_c[33:17]   = py_r;
      data_c[50:34]   = pz_r;
      data_c[66:51]   = nx_r;
      data_c[82:67]   = ny_r;
      data_c[98:83]   = nz_r;
      data_c[115:99]  = u_r;
      data_c[132:116] = v_r;
    end else if (e_r == 3'd1) begin
      kind_c = spmg_pkg::KIND_BMIN;
      last_c = 1'b0;
      data_c[16:0]  = bminx_r;
      data_c[33:17] = bminy_r;
      data_c[50:34] = bminz_r;
    end else begin
      kind_c = spmg_pkg::KIND_BMAX;
      last_c = 1'b1;
      data_c[16:0]  = bmaxx_r;
      data_c[33:17] = bmaxy_r;
      data_c[50:34] = bmaxz_r;
    end
  end

  // State and control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= spmg_pkg::ST_IDLE;
      out_tvalid_r <= 1'b0;
      radius_r     <= 16'd256;
      wang_r       <= 16'd12868;
      hang_r       <= 16'd12868;
      ncols_r      <= 8'd1;
      nrows_r      <= 8'd1;
    end else begin
      state_r <= state_nxt;
      if (emit_load)       out_tvalid_r <= 1'b1;
      else if (out_tready) out_tvalid_r <= 1'b0;
      if (cfg_valid) begin
        case (cfg_addr)
          spmg_pkg::REG_RADIUS: radius_r <= cfg_data;
          spmg_pkg::REG_WIDTH:  wang_r   <= cfg_data;
          spmg_pkg::REG_HEIGHT: hang_r   <= cfg_data;
          spmg_pkg::REG_COLS:   ncols_r  <= cfg_data[7:0];
          spmg_pkg::REG_ROWS:   nrows_r  <= cfg_data[7:0];
          default: ;
        endcase
      end
    end
  end

  // Bounding box registers.
  always_ff @(posedge clk) begin
    if (!rst_n || (emit_load && !cmd_r && e_r == 3'd2)) begin
      bminx_r <= spmg_pkg::BOUND_HI;
      bminy_r <= spmg_pkg::BOUND_HI;
      bminz_r <= spmg_pkg::BOUND_HI;
      bmaxx_r <= spmg_pkg::BOUND_LO;
      bmaxy_r <= spmg_pkg::BOUND_LO;
      bmaxz_r <= spmg_pkg::BOUND_LO;
    end else if (state_r == spmg_pkg::ST_BND) begin
      if (px_r < bminx_r) bminx_r <= px_r;
      if (py_r < bminy_r) bminy_r <= py_r;
      if (pz_r < bminz_r) bminz_r <= pz_r;
      if (px_r > bmaxx_r) bmaxx_r <= px_r;
      if (py_r > bmaxy_r) bmaxy_r <= py_r;
      if (pz_r > bmaxz_r) bmaxz_r <= pz_r;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state_r)
      spmg_pkg::ST_IDLE: begin
        cmd_r     <= in_tuser[0];
        div_sel_r <= 1'b0;
        dcnt_r    <= 5'd0;
        rem_r     <= 8'd0;
        mstep_r   <= spmg_pkg::MS_PHI;
        e_r       <= 3'd0;
        if (in_tuser[0]) begin
          row_r <= (in_tdata[7:0] > rows_eff - 8'd1) ? rows_eff - 8'd1 : in_tdata[7:0];
          col_r <= (in_tdata[15:8] > cols_eff - 8'd1) ? cols_eff - 8'd1 : in_tdata[15:8];
          n_r   <= 3'd6;
        end else begin
          row_r <= (in_tdata[7:0] > rows_eff) ? rows_eff : in_tdata[7:0];
          col_r <= (in_tdata[15:8] > cols_eff) ? cols_eff : in_tdata[15:8];
          fin_r <= (in_tdata[7:0] >= rows_eff) && (in_tdata[15:8] >= cols_eff);
          n_r   <= ((in_tdata[7:0] >= rows_eff) && (in_tdata[15:8] >= cols_eff)) ?
                   3'd3 : 3'd1;
          dv_r  <= {((in_tdata[7:0] > rows_eff) ? rows_eff : in_tdata[7:0]), 16'd0};
        end
      end
      spmg_pkg::ST_QIDX: begin
        bl_r <= 16'(row_r) * (16'(cols_eff) + 16'd1) + 16'(col_r);
      end
      spmg_pkg::ST_DIV: begin
        if (dcnt_r == 5'd23) begin
          if (!div_sel_r) v_r <= 17'({dv_r[22:0], dge});
          else            u_r <= 17'({dv_r[22:0], dge});
          div_sel_r <= 1'b1;
          dcnt_r    <= 5'd0;
          rem_r     <= 8'd0;
          dv_r      <= {col_r, 16'd0};
        end else begin
          dcnt_r <= dcnt_r + 5'd1;
          rem_r  <= dge ? 8'(dtrial - {1'b0, dsor}) : dtrial[7:0];
          dv_r   <= {dv_r[22:0], dge};
        end
      end
      spmg_pkg::ST_MUL: prod_r <= mul_a * mul_b;
      spmg_pkg::ST_USE: begin
        case (mstep_r)
          spmg_pkg::MS_PHI:
            ang_r <= $signed({1'b0, prod_r[32:16]}) - $signed({3'b000, hang_r[15:1]});
          spmg_pkg::MS_THETA:
            ang_r <= $signed({1'b0, prod_r[32:16]}) - $signed({3'b000, wang_r[15:1]});
          spmg_pkg::MS_NX: nx_r <= (radius_r == 16'd0) ? 16'sd0 : nrm_c;
          spmg_pkg::MS_NZ: nz_r <= (radius_r == 16'd0) ? 16'sd0 : nrm_c;
          spmg_pkg::MS_PY: begin
            py_r <= p14[16:0];
            ny_r <= (radius_r == 16'd0) ? 16'sd0 : sp_r;
          end
          spmg_pkg::MS_RCP: q_r  <= prod_r[33:0];
          spmg_pkg::MS_PX:  px_r <= p28[16:0];
          default:          pz_r <= p28[16:0];
        endcase
        if (mstep_r != spmg_pkg::MS_PHI && mstep_r != spmg_pkg::MS_THETA)
          mstep_r <= mstep_r + 3'd1;
      end
      spmg_pkg::ST_RED: begin
        neg_r <= fold;
        z_r   <= 20'(a2) <<< 3;
        x_r   <= spmg_pkg::CORDIC_X0;
        y_r   <= 28'sd0;
        it_r  <= '0;
      end
      spmg_pkg::ST_CORD: begin
        if (z_r >= 0) begin
          x_r <= x_r - dx;
          y_r <= y_r + dy;
          z_r <= z_r - atn;
        end else begin
          x_r <= x_r + dx;
          y_r <= y_r - dy;
          z_r <= z_r + atn;
        end
        it_r <= it_r + ITW'(1);
      end
      spmg_pkg::ST_CRND: begin
        if (mstep_r == spmg_pkg::MS_PHI) begin
          cp_r <= xr_c;
          sp_r <= yr_c;
        end else begin
          ct_r <= xr_c;
          st_r <= yr_c;
        end
        mstep_r <= mstep_r + 3'd1;
      end
      spmg_pkg::ST_EMIT: begin
        if (out_free) begin
          e_r     <= e_r + 3'd1;
          okind_r <= kind_c;
          olast_r <= last_c;
          odata_r <= data_c;
        end
      end
      default: ;
    endcase
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tuser  = okind_r;
  assign out_tlast  = olast_r;
  assign out_tdata  = odata_r;

  // The CORDIC counter never passes the last step.
  a_cord_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == spmg_pkg::ST_CORD) |-> (it_r <= ITW'(CORDIC_STEPS - 1)))
    else $error("CORDIC step count overran");

  // Once an item is taken the block stays busy for the next cycle.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_tready)
    else $error("block ready right after accepting an item");

  // The emission index stays below the number of results of the item.
  a_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == spmg_pkg::ST_EMIT) |-> (e_r < n_r))
    else $error("emission index out of range");

  // Issuing the bounds maximum re-arms the box.
  a_rearm: assert property (@(posedge clk) disable iff (!rst_n)
    (emit_load && !cmd_r && e_r == 3'd2) |=>
      (bminx_r == spmg_pkg::BOUND_HI && bmaxz_r == spmg_pkg::BOUND_LO))
    else $error("bounds not re-armed");

endmodule
